[rtl/sti_pkg.sv]
package sti_pkg;

  localparam int SensorCount     = 32;
  localparam int PointsPerSensor = 16;
  localparam int TableDepth      = SensorCount * PointsPerSensor;
  localparam int AddrW           = $clog2(TableDepth);
  localparam int IdxW            = $clog2(PointsPerSensor + 1);

  localparam int SensorW = 5;
  localparam int PointW  = 4;
  localparam int CodeW   = 12;
  localparam int RegW    = 8;
  localparam int ResultW = 9;
  localparam int RemW    = 16;
  localparam int QuotW   = 4;
  localparam int SumW    = 10;

  localparam logic [RegW-1:0] OffsetReset = 8'd60;
  localparam logic [RegW-1:0] ResultCap   = 8'd199;
  localparam int              StepMm      = 10;

  localparam logic ModeLoad    = 1'b0;
  localparam logic ModeConvert = 1'b1;

  localparam logic CfgBaseOffset = 1'b0;
  localparam logic CfgInvertBase = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StCmp,
    StDiv,
    StDone
  } sti_state_e;

  typedef struct packed {
    logic                     accept;
    logic                     rd_issue;
    logic                     cmp_step;
    logic                     div_step;
    logic [$clog2(QuotW)-1:0] div_bit;
    logic                     out_load;
  } sti_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic below;
    logic idx_low;
  } sti_sts_t;

endpackage

[rtl/sti_ctrl.sv]
module sti_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_mode_i,
  input  logic              out_stall_i,
  input  sti_pkg::sti_sts_t sts_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output sti_pkg::sti_cmd_t cmd_o
);
  import sti_pkg::*;

  sti_state_e               state_q, state_d;
  logic [$clog2(QuotW)-1:0] div_cnt_q, div_cnt_d;
  logic                     out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    div_cnt_d   = div_cnt_q;
    cmd_o       = '0;
    cmd_o.div_bit = div_cnt_q;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_mode_i == ModeConvert) state_d = StRead;
        end
      end
      StRead: begin
        if (sts_i.scan_end) begin
          state_d = StDone;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = StCmp;
        end
      end
      StCmp: begin
        cmd_o.cmp_step = 1'b1;
        if (sts_i.below) begin
          state_d = StRead;
        end else if (sts_i.idx_low) begin
          state_d = StDone;
        end else begin
          div_cnt_d = '1;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q - 1'b1;
        if (div_cnt_q == '0) state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/sti_datapath.sv]
module sti_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_index_i,
  input  logic [sti_pkg::RegW-1:0]             cfg_data_i,
  input  logic                                 in_mode_i,
  input  logic [sti_pkg::SensorW-1:0]          in_sensor_index_i,
  input  logic [sti_pkg::PointW-1:0]           in_point_index_i,
  input  logic [sti_pkg::CodeW-1:0]            in_table_value_i,
  input  logic [sti_pkg::CodeW-1:0]            in_sample_i,
  input  sti_pkg::sti_cmd_t                    cmd_i,
  output sti_pkg::sti_sts_t                    sts_o,
  output logic signed [sti_pkg::ResultW-1:0]   out_result_mm_o,
  output logic                                 out_beyond_table_o
);
  import sti_pkg::*;

  logic [CodeW-1:0]   mem_q [TableDepth];
  logic [CodeW-1:0]   rd_q;
  logic [RegW-1:0]    base_offset_q, invert_base_q;
  logic [CodeW-1:0]   sample_q, prev_q;
  logic [SensorW-1:0] sensor_q;
  logic               sensor_ok_q;
  logic [IdxW-1:0]    idx_q;
  logic [CodeW-1:0]   den_q;
  logic [RemW-1:0]    rem_q;
  logic [QuotW-1:0]   quot_q;
  logic [ResultW-1:0] result_q;
  logic               beyond_q;

  logic               wr_en;
  logic [AddrW-1:0]   wr_addr, rd_addr;
  logic               below;
  logic [CodeW-1:0]   diff;
  logic [RemW-1:0]    trial;
  logic               at_end;
  logic [SumW-1:0]    sum, pre;
  logic [RegW-1:0]    clamped;
  logic [ResultW-1:0] res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_offset_q <= OffsetReset;
      invert_base_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgBaseOffset: base_offset_q <= cfg_data_i;
        CfgInvertBase: invert_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign wr_en = cmd_i.accept && (in_mode_i == ModeLoad)
              && (int'(in_sensor_index_i) < SensorCount)
              && (int'(in_point_index_i) < PointsPerSensor);
  assign wr_addr = AddrW'(int'(in_sensor_index_i) * PointsPerSensor + int'(in_point_index_i));
  assign rd_addr = AddrW'(int'(sensor_q) * PointsPerSensor + int'(idx_q));

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= in_table_value_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) rd_q <= mem_q[rd_addr];
  end

  assign below = sample_q < rd_q;
  assign diff  = prev_q - sample_q;
  assign trial = RemW'(den_q) << cmd_i.div_bit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q    <= in_sample_i;
      sensor_q    <= in_sensor_index_i;
      sensor_ok_q <= int'(in_sensor_index_i) < SensorCount;
      idx_q       <= '0;
      quot_q      <= '0;
    end
    if (cmd_i.cmp_step) begin
      if (below) begin
        prev_q <= rd_q;
        idx_q  <= idx_q + 1'b1;
      end else begin
        den_q <= prev_q - rd_q;
        rem_q <= (RemW'(diff) << 3) + (RemW'(diff) << 1);
      end
    end
    if (cmd_i.div_step && rem_q >= trial) begin
      rem_q                  <= rem_q - trial;
      quot_q[cmd_i.div_bit]  <= 1'b1;
    end
  end

  assign at_end         = int'(idx_q) == PointsPerSensor;
  assign sts_o.scan_end = at_end || !sensor_ok_q;
  assign sts_o.below    = below;
  assign sts_o.idx_low  = idx_q <= IdxW'(1);

  always_comb begin
    sum = SumW'(StepMm * int'(idx_q)) + SumW'(quot_q) + SumW'(base_offset_q);
    if (at_end) begin
      pre = SumW'(ResultCap);
    end else if (idx_q <= IdxW'(1)) begin
      pre = SumW'(base_offset_q);
    end else begin
      pre = sum;
    end
    clamped = (pre > SumW'(ResultCap)) ? ResultCap : pre[RegW-1:0];
    if (invert_base_q != '0) begin
      res = {1'b0, invert_base_q} - {1'b0, clamped};
    end else begin
      res = {1'b0, clamped};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      result_q <= res;
      beyond_q <= at_end;
    end
  end

  assign out_result_mm_o    = signed'(result_q);
  assign out_beyond_table_o = beyond_q;

endmodule

[rtl/sensor_table_interpolator_unit.sv]
// Piecewise-linear calibration lookup. Each of 32 sensors owns a row of 16 descending 12-bit
// points held in a table RAM. A load transaction (mode 0) writes one point and gives no
// result. A convert transaction (mode 1) scans its row from point 0, reading the RAM and then
// comparing for each point, until a point not above the sample is found or the row ends;
// for an index of 2 or more a restoring divide produces the interpolation fraction, then the
// output register is loaded once it is free. The output register lets the next transaction
// be accepted while a result is still stalled. Table entries read before being loaded give
// undefined results.
// Write base_offset and invert_base only while the block is idle.
module sensor_table_interpolator_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_index_i,
  input  logic [sti_pkg::RegW-1:0]             cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 in_mode_i,
  input  logic [sti_pkg::SensorW-1:0]          in_sensor_index_i,
  input  logic [sti_pkg::PointW-1:0]           in_point_index_i,
  input  logic [sti_pkg::CodeW-1:0]            in_table_value_i,
  input  logic [sti_pkg::CodeW-1:0]            in_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [sti_pkg::ResultW-1:0]   out_result_mm_o,
  output logic                                 out_beyond_table_o
);
  import sti_pkg::*;

  sti_cmd_t cmd;
  sti_sts_t sts;

  sti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_mode_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  sti_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_mode_i          (in_mode_i),
    .in_sensor_index_i  (in_sensor_index_i),
    .in_point_index_i   (in_point_index_i),
    .in_table_value_i   (in_table_value_i),
    .in_sample_i        (in_sample_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_result_mm_o    (out_result_mm_o),
    .out_beyond_table_o (out_beyond_table_o)
  );

endmodule

[sim/sensor_table_interpolator_unit_test.sv]
module sensor_table_interpolator_unit_test;
  import sti_pkg::*;

  typedef struct {
    logic               mode;
    logic [SensorW-1:0] sensor;
    logic [PointW-1:0]  point;
    logic [CodeW-1:0]   value;
    logic [CodeW-1:0]   sample;
  } cal_op_t;

  typedef struct {
    logic [ResultW-1:0] mm;
    logic               beyond;
  } distance_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic                      cfg_index_i = CfgBaseOffset;
  logic [RegW-1:0]           cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      in_mode_i = ModeLoad;
  logic [SensorW-1:0]        in_sensor_index_i = '0;
  logic [PointW-1:0]         in_point_index_i = '0;
  logic [CodeW-1:0]          in_table_value_i = '0;
  logic [CodeW-1:0]          in_sample_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [ResultW-1:0] out_result_mm_o;
  logic                      out_beyond_table_o;

  sensor_table_interpolator_unit dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [CodeW-1:0] cal_model [SensorCount][PointsPerSensor];
  logic [RegW-1:0]  offset_model = OffsetReset;
  logic [RegW-1:0]  invert_model = '0;

  // stimulus planning shadow
  int               cal_plan [SensorCount][PointsPerSensor];
  logic [PointsPerSensor-1:0] row_loaded [SensorCount];

  cal_op_t   pending_ops[$];
  distance_t expected_distances[$];
  cal_op_t   cur_op;

  int send_idle_pct = 32;
  int stall_pct = 63;
  int planned = 0;
  int loads_sent = 0;
  int converts_sent = 0;
  int beyond_seen = 0;
  int results_seen = 0;
  int errors = 0;

  function automatic distance_t predict_distance(input logic [SensorW-1:0] s,
                                                 input logic [CodeW-1:0] smp);
    distance_t d;
    int idx;
    int prev;
    int cur;
    int r;
    idx = 0;
    while (idx < PointsPerSensor && smp < cal_model[s][idx]) idx++;
    d.beyond = (idx == PointsPerSensor);
    if (d.beyond) begin
      r = ResultCap;
    end else if (idx <= 1) begin
      r = offset_model;
    end else begin
      prev = cal_model[s][idx-1];
      cur  = cal_model[s][idx];
      r = StepMm * idx + (StepMm * (prev - smp)) / (prev - cur) + offset_model;
    end
    if (r > ResultCap) r = ResultCap;
    if (invert_model != 0) r = invert_model - r;
    d.mm = r[ResultW-1:0];
    return d;
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (cur_op.mode == ModeLoad) begin
          cal_model[cur_op.sensor][cur_op.point] = cur_op.value;
          loads_sent++;
        end else begin
          expected_distances.push_back(predict_distance(cur_op.sensor, cur_op.sample));
          converts_sent++;
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_ops.size() == 0 || $urandom_range(99) < send_idle_pct) begin
          in_valid_i <= 1'b0;
        end else begin
          cur_op = pending_ops.pop_front();
          in_valid_i        <= 1'b1;
          in_mode_i         <= cur_op.mode;
          in_sensor_index_i <= cur_op.sensor;
          in_point_index_i  <= cur_op.point;
          in_table_value_i  <= cur_op.value;
          in_sample_i       <= cur_op.sample;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    distance_t want;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_distances.size() == 0) begin
          flag_error($sformatf("unexpected result mm=%0d beyond=%0b",
                               out_result_mm_o, out_beyond_table_o));
        end else begin
          want = expected_distances.pop_front();
          if (want.beyond) beyond_seen++;
          if (want.mm !== out_result_mm_o || want.beyond !== out_beyond_table_o)
            flag_error($sformatf("result %0d: exp mm=%0d beyond=%0b, got mm=%0d beyond=%0b",
                                 results_seen, $signed(want.mm), want.beyond,
                                 out_result_mm_o, out_beyond_table_o));
        end
      end
    end
  end

  task automatic add_load(input int s, input int p, input int v);
    cal_op_t op;
    op.mode   = ModeLoad;
    op.sensor = SensorW'(s);
    op.point  = PointW'(p);
    op.value  = CodeW'(v);
    op.sample = CodeW'($urandom_range(4095));
    pending_ops.push_back(op);
    cal_plan[s][p] = v;
    row_loaded[s][p] = 1'b1;
    planned++;
  endtask

  task automatic add_convert(input int s, input int smp);
    cal_op_t op;
    op.mode   = ModeConvert;
    op.sensor = SensorW'(s);
    op.point  = PointW'($urandom_range(15));
    op.value  = CodeW'($urandom_range(4095));
    op.sample = CodeW'(smp);
    pending_ops.push_back(op);
    planned++;
  endtask

  task automatic load_row(input int s, input bit sorted);
    int vals [PointsPerSensor];
    int v;
    bit rev;
    v = ($urandom_range(3) == 0) ? 4095 : $urandom_range(4095, 1500);
    rev = $urandom_range(1);
    for (int i = 0; i < PointsPerSensor; i++) begin
      vals[i] = sorted ? v : $urandom_range(4095);
      v = v - $urandom_range(350);
      if (v < 0) v = 0;
    end
    for (int i = 0; i < PointsPerSensor; i++) begin
      if (rev) add_load(s, PointsPerSensor - 1 - i, vals[PointsPerSensor - 1 - i]);
      else add_load(s, i, vals[i]);
    end
  endtask

  function automatic int pick_sample(input int s);
    int k;
    int r;
    k = $urandom_range(PointsPerSensor - 1, 1);
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 16) return 4095;
    if (r < 40) return cal_plan[s][$urandom_range(PointsPerSensor - 1)];
    if (r < 90) return $urandom_range(cal_plan[s][k], cal_plan[s][k-1]);
    return $urandom_range(4095);
  endfunction

  task automatic plan_directed();
    for (int i = 0; i < PointsPerSensor; i++) add_load(31, i, 4095 - 250 * i);
    add_load(0, 15, 0);
    add_convert(31, 4095);
    add_convert(31, 4000);
    add_convert(31, 3845);
    add_convert(31, 3700);
    add_convert(31, 3595);
    add_convert(31, 2000);
    add_convert(31, 345);
    add_convert(31, 0);
  endtask

  task automatic plan_random(input int budget);
    int start;
    int full[$];
    int r;
    int s;
    start = planned;
    while (planned - start < budget) begin
      full.delete();
      for (int i = 0; i < SensorCount; i++) if (&row_loaded[i]) full.push_back(i);
      r = $urandom_range(99);
      if (r < 5 || full.size() == 0) begin
        load_row($urandom_range(SensorCount - 1), $urandom_range(99) < 85);
      end else if (r < 13) begin
        add_load($urandom_range(SensorCount - 1), $urandom_range(PointsPerSensor - 1),
                 $urandom_range(4095));
      end else begin
        s = full[$urandom_range(full.size() - 1)];
        add_convert(s, pick_sample(s));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_valid_i || expected_distances.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [RegW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgBaseOffset) offset_model = val;
    else invert_model = val;
  endtask

  initial begin
    for (int i = 0; i < SensorCount; i++) row_loaded[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_drained();
        case (ph)
          1: begin
            write_reg(CfgBaseOffset, 8'd0);
            write_reg(CfgInvertBase, 8'd0);
          end
          2: begin
            write_reg(CfgBaseOffset, 8'd199);
            write_reg(CfgInvertBase, 8'd255);
          end
          3: begin
            write_reg(CfgBaseOffset, 8'd255);
            write_reg(CfgInvertBase, 8'd1);
          end
          4: begin
            write_reg(CfgBaseOffset, RegW'($urandom_range(199)));
            write_reg(CfgInvertBase, RegW'($urandom_range(255, 1)));
          end
          default: begin
            write_reg(CfgBaseOffset, RegW'($urandom_range(255)));
            write_reg(CfgInvertBase, 8'd0);
          end
        endcase
      end
      send_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 63 : 0;
      stall_pct     = (ph < 2) ? 63 : (ph < 4) ? 32 : 0;
      if (ph == 0) plan_directed();
      plan_random(255);
    end
    wait_drained();
    $display("Ran %0d loads and %0d conversions (%0d beyond table) over 6 register settings,",
             loads_sent, converts_sent, beyond_seen);
    $display("with sender gaps, receiver stalls and both-free stretches; %0d errors.", errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected", expected_distances.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
rtl/sti_pkg.sv
rtl/sti_ctrl.sv
rtl/sti_datapath.sv
rtl/sensor_table_interpolator_unit.sv
sim/sensor_table_interpolator_unit_test.sv
